// ===== hw/rtl/tud_pkg.sv =====
// tud_pkg: widths and scale constants for the tick count to time units converter.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
package tud_pkg;

	localparam int SEC_W = 63;  // tick count, whole seconds and totals
	localparam int NS_W  = 30;  // nanosecond part
	localparam int PS_W  = 40;  // picosecond part
	localparam int CFG_W = 32;  // configuration write data

	localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;
	localparam logic [PS_W-1:0] PS_PER_S = 40'd1000000000000;
	localparam logic [SEC_W-1:0] MAX63   = {SEC_W{1'b1}};

	// 1e9 = NS_HI * 2^15 + NS_LO, keeps the fraction products narrow
	localparam int NS_SPLIT = 15;
	localparam logic [NS_SPLIT-1:0] NS_HI = 15'd30517;
	localparam logic [NS_SPLIT-1:0] NS_LO = 15'd18944;

	// ps part = ns part * 1000 + the next three decimal digits
	localparam int MILLE_W = 10;
	localparam logic [MILLE_W-1:0] MILLE = 10'd1000;

	localparam int CHUNK_W = 21;  // seconds split in three for the totals

endpackage

// ===== hw/rtl/tud_tick_if.sv =====
// tud_tick_if: request channel carrying one tick count.
// Depends on tud_pkg.
`timescale 1ns / 1ps
interface tud_tick_if
	import tud_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [SEC_W-1:0] tick_count;

	modport source (output valid, output tick_count, input ready);
	modport sink   (input valid, input tick_count, output ready);
endinterface

// ===== hw/rtl/tud_time_if.sv =====
// tud_time_if: result channel carrying the converted time units.
// Depends on tud_pkg.
`timescale 1ns / 1ps
interface tud_time_if
	import tud_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [SEC_W-1:0] whole_seconds;
	logic [NS_W-1:0]  nanosecond_part;
	logic [PS_W-1:0]  picosecond_part;
	logic [SEC_W-1:0] total_nanoseconds;
	logic [SEC_W-1:0] total_picoseconds;
	logic             ns_overflow;
	logic             ps_overflow;

	modport source (output valid, output whole_seconds, output nanosecond_part,
		output picosecond_part, output total_nanoseconds, output total_picoseconds,
		output ns_overflow, output ps_overflow, input ready);
	modport sink (input valid, input whole_seconds, input nanosecond_part,
		input picosecond_part, input total_nanoseconds, input total_picoseconds,
		input ns_overflow, input ps_overflow, output ready);
endinterface

// ===== hw/rtl/tud_cell.sv =====
// tud_cell: one restoring division step; shifts one numerator bit into the
// partial remainder and one quotient bit into the numerator word. No dependencies.
`timescale 1ns / 1ps
module tud_cell #(
	parameter int RW = 32,
	parameter int NW = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [RW-1:0] rate,
	input  logic          vld_prev,
	input  logic [RW-1:0] rem_prev,
	input  logic [NW-1:0] num_prev,
	output logic          vld_q,
	output logic [RW-1:0] rem_q,
	output logic [NW-1:0] num_q
);

	logic [RW:0] rem2;
	logic [RW:0] diff;
	logic        ge;

	assign rem2 = {rem_prev, num_prev[NW-1]};
	assign diff = rem2 - {1'b0, rate};
	assign ge   = rem2 >= {1'b0, rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[RW-1:0] : rem2[RW-1:0];
			num_q <= {num_prev[NW-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/tud_chain.sv =====
// tud_chain: NW division cells in a row; numerator in, quotient and remainder out.
// Depends on tud_cell.
`timescale 1ns / 1ps
module tud_chain #(
	parameter int RW = 32,
	parameter int NW = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [RW-1:0] rate,
	input  logic          vld_prev,
	input  logic [RW-1:0] rem_prev,
	input  logic [NW-1:0] num_prev,
	output logic          vld_q,
	output logic [RW-1:0] rem_q,
	output logic [NW-1:0] num_q
);

	logic          vld_c [NW+1];
	logic [RW-1:0] rem_c [NW+1];
	logic [NW-1:0] num_c [NW+1];

	assign vld_c[0] = vld_prev;
	assign rem_c[0] = rem_prev;
	assign num_c[0] = num_prev;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		tud_cell #(.RW(RW), .NW(NW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.rate     (rate),
			.vld_prev (vld_c[i]),
			.rem_prev (rem_c[i]),
			.num_prev (num_c[i]),
			.vld_q    (vld_c[i+1]),
			.rem_q    (rem_c[i+1]),
			.num_q    (num_c[i+1])
		);
	end

	assign vld_q = vld_c[NW];
	assign rem_q = rem_c[NW];
	assign num_q = num_c[NW];

endmodule

// ===== hw/rtl/tud_delay.sv =====
// tud_delay: enabled shift line that keeps side data level with a division chain.
// No dependencies.
`timescale 1ns / 1ps
module tud_delay #(
	parameter int W     = 63,
	parameter int DEPTH = 10
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

// ===== hw/rtl/tick_count_to_time_units.sv =====
// tick_count_to_time_units: top level, tick count to seconds, fractions and totals.
// Depends on tud_pkg, tud_tick_if, tud_time_if, tud_chain, tud_delay.
//
// Channel     Dir  Handshake      Carries
// ticks       in   valid/ready    tick_count (63 b)
// units       out  valid/ready    seconds, ns/ps parts, ns/ps totals, overflow flags
// cfg_wr_*    in   write enable   tick_rate (32 b, low RATE_BITS kept)
//
// One request enters per cycle unless the pipeline is frozen; each passes
// through 63 cells for seconds, 30 for the ns part, 10 for the extra ps
// digits, plus six product/sum registers.
// The whole pipeline advances together; it freezes only while the output
// register holds a result that is not taken. Reset clears all valid flags
// and loads the rate with 1e9; payload registers are not reset.
`timescale 1ns / 1ps
module tick_count_to_time_units
	import tud_pkg::*;
#(
	parameter int RATE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	tud_tick_if.sink         ticks,
	tud_time_if.source       units
);

	localparam int RW = RATE_BITS;
	localparam logic [RW-1:0] RATE_RST_RAW = RW'(64'd1000000000);
	localparam logic [RW-1:0] RATE_RST     = (RATE_RST_RAW == '0) ? RW'(1) : RATE_RST_RAW;

	// rate register; zero is held as one so the divider never sees zero
	logic [RW-1:0]       rate_q;
	logic [RW+CFG_W-1:0] cfg_ext;
	logic [RW-1:0]       rate_d;

	assign cfg_ext = {{RW{1'b0}}, cfg_wr_data};
	assign rate_d  = cfg_ext[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RST;
		end else if (cfg_wr_en) begin
			rate_q <= (rate_d == '0) ? RW'(1) : rate_d;
		end
	end

	// global advance: move unless the output holds an untaken result
	logic en;
	logic vld_q;
	assign en          = !vld_q || units.ready;
	assign ticks.ready = en;

	// seconds = ticks / rate, remainder = fraction in ticks
	logic             a_vld;
	logic [RW-1:0]    a_frac;
	logic [SEC_W-1:0] a_sec;

	tud_chain #(.RW(RW), .NW(SEC_W)) u_sec_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rate     (rate_q),
		.vld_prev (ticks.valid),
		.rem_prev ('0),
		.num_prev (ticks.tick_count),
		.vld_q    (a_vld),
		.rem_q    (a_frac),
		.num_q    (a_sec)
	);

	// fraction * 1e9 in two narrow products, then summed
	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [RW+NS_SPLIT-1:0]  fr_lo_s1, fr_hi_s1;
	logic [SEC_W-1:0]        sec_s1, sec_s2;
	logic [RW+NS_W-1:0]      n_s2;

	// ns part by division of fraction*1e9; its remainder feeds the ps digits
	logic             c_vld;
	logic [RW-1:0]    c_rem;
	logic [NS_W-1:0]  c_nsp;
	logic [SEC_W-1:0] c_sec;

	logic [RW+MILLE_W-1:0] m_s3;
	logic [NS_W-1:0]       nsp_s3;
	logic [SEC_W-1:0]      sec_s3;

	logic               e_vld;
	logic [MILLE_W-1:0] e_dig;
	logic [NS_W-1:0]    e_nsp;
	logic [SEC_W-1:0]   e_sec;

	logic [PS_W-1:0]  psp_s4;
	logic [NS_W-1:0]  nsp_s4;
	logic [SEC_W-1:0] sec_s4;
	logic [CHUNK_W+NS_W-1:0] pn0_s4, pn1_s4, pn2_s4;
	logic [CHUNK_W+PS_W-1:0] pp0_s4, pp1_s4, pp2_s4;

	logic [PS_W-1:0]         psp_s5;
	logic [NS_W-1:0]         nsp_s5;
	logic [SEC_W-1:0]        sec_s5;
	logic [CHUNK_W+NS_W+22:0] ns01_s5;
	logic [CHUNK_W+PS_W+22:0] ps01_s5;
	logic [CHUNK_W+NS_W-1:0] pn2_s5;
	logic [CHUNK_W+PS_W-1:0] pp2_s5;

	tud_chain #(.RW(RW), .NW(NS_W)) u_ns_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rate     (rate_q),
		.vld_prev (vld_s2),
		.rem_prev (n_s2[RW+NS_W-1:NS_W]),
		.num_prev (n_s2[NS_W-1:0]),
		.vld_q    (c_vld),
		.rem_q    (c_rem),
		.num_q    (c_nsp)
	);

	tud_delay #(.W(SEC_W), .DEPTH(NS_W)) u_sec_dly_ns (
		.clk  (clk),
		.en   (en),
		.din  (sec_s2),
		.dout (c_sec)
	);

	// three more decimal digits: remainder * 1000 / rate
	tud_chain #(.RW(RW), .NW(MILLE_W)) u_ps_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rate     (rate_q),
		.vld_prev (vld_s3),
		.rem_prev (m_s3[RW+MILLE_W-1:MILLE_W]),
		.num_prev (m_s3[MILLE_W-1:0]),
		.vld_q    (e_vld),
		.rem_q    (),
		.num_q    (e_dig)
	);

	tud_delay #(.W(SEC_W), .DEPTH(MILLE_W)) u_sec_dly_ps (
		.clk  (clk),
		.en   (en),
		.din  (sec_s3),
		.dout (e_sec)
	);

	tud_delay #(.W(NS_W), .DEPTH(MILLE_W)) u_nsp_dly_ps (
		.clk  (clk),
		.en   (en),
		.din  (nsp_s3),
		.dout (e_nsp)
	);

	// totals: full-width sums, overflow is any bit above bit 62
	logic [CHUNK_W+NS_W+42:0] tns_full;
	logic [CHUNK_W+PS_W+42:0] tps_full;
	logic                     ns_ovf, ps_ovf;

	assign tns_full = (CHUNK_W+NS_W+43)'(ns01_s5)
		+ (CHUNK_W+NS_W+43)'({pn2_s5, 42'b0});
	assign tps_full = (CHUNK_W+PS_W+43)'(ps01_s5)
		+ (CHUNK_W+PS_W+43)'({pp2_s5, 42'b0});
	assign ns_ovf = |tns_full[CHUNK_W+NS_W+42:SEC_W];
	assign ps_ovf = |tps_full[CHUNK_W+PS_W+42:SEC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= a_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= c_vld;
			vld_s4 <= e_vld;
			vld_s5 <= vld_s4;
			vld_q  <= vld_s5;
		end
	end

	logic [SEC_W-1:0] sec_q, tns_q, tps_q;
	logic [NS_W-1:0]  nsp_q;
	logic [PS_W-1:0]  psp_q;
	logic             nsovf_q, psovf_q;

	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			fr_lo_s1 <= (RW+NS_SPLIT)'(a_frac) * (RW+NS_SPLIT)'(NS_LO);
			fr_hi_s1 <= (RW+NS_SPLIT)'(a_frac) * (RW+NS_SPLIT)'(NS_HI);
			sec_s1   <= a_sec;
			// s2: fraction*1e9 < rate*2^30, so its top bits sit below the rate
			n_s2   <= {fr_hi_s1, {NS_SPLIT{1'b0}}} + (RW+NS_W)'(fr_lo_s1);
			sec_s2 <= sec_s1;
			// s3: remainder*1000 < rate*2^10
			m_s3   <= (RW+MILLE_W)'(c_rem) * (RW+MILLE_W)'(MILLE);
			nsp_s3 <= c_nsp;
			sec_s3 <= c_sec;
			// s4
			psp_s4 <= PS_W'(e_nsp) * PS_W'(MILLE) + PS_W'(e_dig);
			nsp_s4 <= e_nsp;
			sec_s4 <= e_sec;
			pn0_s4 <= (CHUNK_W+NS_W)'(e_sec[CHUNK_W-1:0]) * (CHUNK_W+NS_W)'(NS_PER_S);
			pn1_s4 <= (CHUNK_W+NS_W)'(e_sec[2*CHUNK_W-1:CHUNK_W])
				* (CHUNK_W+NS_W)'(NS_PER_S);
			pn2_s4 <= (CHUNK_W+NS_W)'(e_sec[SEC_W-1:2*CHUNK_W])
				* (CHUNK_W+NS_W)'(NS_PER_S);
			pp0_s4 <= (CHUNK_W+PS_W)'(e_sec[CHUNK_W-1:0]) * (CHUNK_W+PS_W)'(PS_PER_S);
			pp1_s4 <= (CHUNK_W+PS_W)'(e_sec[2*CHUNK_W-1:CHUNK_W])
				* (CHUNK_W+PS_W)'(PS_PER_S);
			pp2_s4 <= (CHUNK_W+PS_W)'(e_sec[SEC_W-1:2*CHUNK_W])
				* (CHUNK_W+PS_W)'(PS_PER_S);
			// s5: low two chunks plus the part
			ns01_s5 <= (CHUNK_W+NS_W+23)'(pn0_s4)
				+ (CHUNK_W+NS_W+23)'({pn1_s4, {CHUNK_W{1'b0}}})
				+ (CHUNK_W+NS_W+23)'(nsp_s4);
			ps01_s5 <= (CHUNK_W+PS_W+23)'(pp0_s4)
				+ (CHUNK_W+PS_W+23)'({pp1_s4, {CHUNK_W{1'b0}}})
				+ (CHUNK_W+PS_W+23)'(psp_s4);
			pn2_s5 <= pn2_s4;
			pp2_s5 <= pp2_s4;
			psp_s5 <= psp_s4;
			nsp_s5 <= nsp_s4;
			sec_s5 <= sec_s4;
			// output register
			sec_q   <= sec_s5;
			nsp_q   <= nsp_s5;
			psp_q   <= psp_s5;
			tns_q   <= ns_ovf ? MAX63 : tns_full[SEC_W-1:0];
			tps_q   <= ps_ovf ? MAX63 : tps_full[SEC_W-1:0];
			nsovf_q <= ns_ovf;
			psovf_q <= ps_ovf;
		end
	end

	assign units.valid             = vld_q;
	assign units.whole_seconds     = sec_q;
	assign units.nanosecond_part   = nsp_q;
	assign units.picosecond_part   = psp_q;
	assign units.total_nanoseconds = tns_q;
	assign units.total_picoseconds = tps_q;
	assign units.ns_overflow       = nsovf_q;
	assign units.ps_overflow       = psovf_q;

	// ps total is at least 1000 times the ns total, so it saturates too
	assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && units.ns_overflow |-> units.ps_overflow)
		else $error("ns overflow without ps overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		units.valid |-> units.nanosecond_part < NS_PER_S)
		else $error("ns part out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		units.valid |-> units.picosecond_part < PS_PER_S)
		else $error("ps part out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && !units.ps_overflow |->
		units.total_picoseconds >= SEC_W'(units.picosecond_part))
		else $error("ps total below ps part");

endmodule
